// ===== rtl/clcb_pkg.sv =====
// Shared constants for the code lock countdown beeper: field widths, register
// indexes, key and mode codes, and parameter defaults. No dependencies.
package clcb_pkg;

   // field widths
   localparam int OP_W       = 1;
   localparam int KEY_W      = 5;
   localparam int MODE_W     = 2;
   localparam int DCNT_W     = 3;
   localparam int DIGIT_W    = 4;
   localparam int DIGITS_W   = 28;
   localparam int SECS_W     = 7;
   localparam int BASE_W     = 10;
   localparam int STEP_W     = 7;
   localparam int HALF_W     = 14;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_SECS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_BASE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_STEP   = 2'd3;

   localparam logic [DIGITS_W-1:0] SECRET_CODE_RST = 28'd134632759;
   localparam logic [SECS_W-1:0]   COUNT_SECS_RST  = 7'd40;
   localparam logic [BASE_W-1:0]   BEEP_BASE_RST   = 10'd30;
   localparam logic [STEP_W-1:0]   BEEP_STEP_RST   = 7'd3;

   // operation codes
   localparam logic [OP_W-1:0] OP_KEY  = 1'b0;
   localparam logic [OP_W-1:0] OP_TICK = 1'b1;

   // key codes
   localparam logic [KEY_W-1:0] KEY_DIGIT_LO = 5'd1;
   localparam logic [KEY_W-1:0] KEY_ZERO     = 5'd10;
   localparam logic [KEY_W-1:0] KEY_CLEAR    = 5'd14;
   localparam logic [KEY_W-1:0] KEY_ENTER    = 5'd16;

   // modes
   localparam logic [MODE_W-1:0] MODE_ENTRY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALARM = 2'd2;

   localparam logic [HALF_W-1:0] HALF_MAX = 14'd16383;

   // parameter defaults
   localparam int CODE_LENGTH_DEF      = 7;
   localparam int TICKS_PER_SECOND_DEF = 1000;

endpackage

// ===== rtl/clcb_req_if.sv =====
// Request channel of the code lock countdown beeper: valid/ready plus the
// key press or tick payload. Depends on clcb_pkg.
interface clcb_req_if;
   logic                          valid;
   logic                          ready;
   logic [clcb_pkg::OP_W-1:0]     operation;
   logic [clcb_pkg::KEY_W-1:0]    key_code;

   modport source (output valid, output operation, output key_code, input ready);
   modport sink   (input valid, input operation, input key_code, output ready);
endinterface

// ===== rtl/clcb_rsp_if.sv =====
// Response channel of the code lock countdown beeper: valid/ready plus the
// state snapshot taken after each transaction. Depends on clcb_pkg.
interface clcb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [clcb_pkg::MODE_W-1:0]      mode;
   logic [clcb_pkg::DCNT_W-1:0]      digit_count;
   logic [clcb_pkg::DIGITS_W-1:0]    entered_digits;
   logic [clcb_pkg::SECS_W-1:0]      seconds_left;
   logic                             tone_enable;
   logic                             error_flag;

   modport source (output valid, output mode, output digit_count, output entered_digits,
                   output seconds_left, output tone_enable, output error_flag,
                   input ready);
   modport sink   (input valid, input mode, input digit_count, input entered_digits,
                   input seconds_left, input tone_enable, input error_flag,
                   output ready);
endinterface

// ===== rtl/code_lock_countdown_beeper.sv =====
// Top level of the keypad code lock with countdown beeper.
// Depends on clcb_pkg, clcb_req_if and clcb_rsp_if.
//
//   channel   dir   handshake            payload
//   req_chan  in    valid / ready        operation, key_code
//   rsp_chan  out   valid / ready        mode, digit_count, entered_digits,
//                                        seconds_left, tone_enable, error_flag
//   csr_*     in    csr_we (no ready)    csr_index, csr_wdata
//
// Two register stages: input register, then next-state logic into the state
// and response registers; rsp valid is registered in the response stage. One
// transaction per cycle is sustained while rsp_chan.ready is high. The state
// update is the single path between the stages (7x7 multiply, add, saturate
// for the half period). Reset is synchronous, active high, and restores the
// register defaults. A stalled response holds the input register; req_chan.ready
// drops only when both stages are full and rsp_chan.ready is low.
module code_lock_countdown_beeper #(
   parameter int CODE_LENGTH      = clcb_pkg::CODE_LENGTH_DEF,
   parameter int TICKS_PER_SECOND = clcb_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   clcb_req_if.sink                          req_chan,
   clcb_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [clcb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clcb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import clcb_pkg::*;

   localparam int CNT_W  = $clog2(CODE_LENGTH + 1);
   localparam int MS_W   = $clog2(TICKS_PER_SECOND + 1);
   localparam int PACK_N = (CODE_LENGTH < 7) ? CODE_LENGTH : 7;

   typedef logic [DIGIT_W-1:0] digit_type;

   // configuration registers
   logic [DIGITS_W-1:0] secret_ff;
   logic [SECS_W-1:0]   cd_secs_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [STEP_W-1:0]   step_ff;

   // input stage
   logic                in_vld_ff;
   logic [OP_W-1:0]     in_op_ff;
   logic [KEY_W-1:0]    in_key_ff;

   // lock state
   logic [MODE_W-1:0]   mode_ff, mode_in;
   digit_type           digit_ff [CODE_LENGTH];
   digit_type           digit_in [CODE_LENGTH];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SECS_W-1:0]   secs_ff, secs_in;
   logic [MS_W-1:0]     ms_ff, ms_in;
   logic [HALF_W-1:0]   half_ff, half_in;
   logic [HALF_W-1:0]   beep_ff, beep_in;
   logic                tone_ff, tone_in;
   logic                err_in;

   // response stage
   logic                out_vld_ff;
   logic [MODE_W-1:0]   out_mode_ff;
   logic [DCNT_W-1:0]   out_cnt_ff;
   logic [DIGITS_W-1:0] out_digits_ff;
   logic [SECS_W-1:0]   out_secs_ff;
   logic                out_tone_ff;
   logic                out_err_ff;

   logic                out_free;
   logic                step_en;
   logic                code_ok;
   logic [31:0]         code_ext;
   logic [DIGITS_W-1:0] packed_in;
   logic [CNT_W+2:0]    cnt_ext;
   logic [HALF_W-1:0]   half_cd;
   logic [HALF_W-1:0]   half_dec;
   logic [SECS_W-1:0]   secs_dec;
   logic [HALF_W-1:0]   beep_inc;
   logic [MS_W-1:0]     ms_inc;

   function automatic logic [HALF_W-1:0] calc_half(input logic [BASE_W-1:0] base,
                                                   input logic [STEP_W-1:0] step,
                                                   input logic [SECS_W-1:0] secs);
      logic [HALF_W-1:0] prod;
      logic [HALF_W:0]   sum;
      prod = HALF_W'(secs) * HALF_W'(step);
      sum  = (HALF_W+1)'(base) + (HALF_W+1)'(prod);
      return sum[HALF_W] ? HALF_MAX : sum[HALF_W-1:0];
   endfunction

   assign out_free       = !out_vld_ff || rsp_chan.ready;
   assign step_en        = in_vld_ff && out_free;
   assign req_chan.ready = !in_vld_ff || out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff  <= SECRET_CODE_RST;
         cd_secs_ff <= COUNT_SECS_RST;
         base_ff    <= BEEP_BASE_RST;
         step_ff    <= BEEP_STEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SECRET_CODE: secret_ff  <= csr_wdata;
            CSR_COUNT_SECS:  cd_secs_ff <= csr_wdata[SECS_W-1:0];
            CSR_BEEP_BASE:   base_ff    <= csr_wdata[BASE_W-1:0];
            CSR_BEEP_STEP:   step_ff    <= csr_wdata[STEP_W-1:0];
            default:         ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff  <= req_chan.operation;
         in_key_ff <= req_chan.key_code;
      end
   end

   // code compare; the nibble past the seventh compares against zero
   assign code_ext = {4'b0, secret_ff};

   always_comb begin
      code_ok = (cnt_ff == CNT_W'(CODE_LENGTH));
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (digit_ff[i] != code_ext[4*i +: 4]) begin
            code_ok = 1'b0;
         end
      end
   end

   assign half_cd  = calc_half(base_ff, step_ff, cd_secs_ff);
   assign secs_dec = secs_ff - SECS_W'(1);
   assign half_dec = calc_half(base_ff, step_ff, secs_dec);
   assign beep_inc = beep_ff + HALF_W'(1);
   assign ms_inc   = ms_ff + MS_W'(1);

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      secs_in = secs_ff;
      ms_in   = ms_ff;
      half_in = half_ff;
      beep_in = beep_ff;
      tone_in = tone_ff;
      err_in  = 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         digit_in[i] = digit_ff[i];
      end

      if (in_op_ff == OP_KEY) begin
         if (mode_ff == MODE_ENTRY) begin
            if (in_key_ff == KEY_CLEAR) begin
               cnt_in = '0;
               for (int i = 0; i < CODE_LENGTH; i++) begin
                  digit_in[i] = '0;
               end
            end else if (in_key_ff == KEY_ENTER) begin
               if (code_ok) begin
                  mode_in = MODE_COUNT;
                  secs_in = cd_secs_ff;
                  ms_in   = '0;
                  beep_in = '0;
                  half_in = half_cd;
                  tone_in = 1'b1;
               end else begin
                  cnt_in = '0;
                  err_in = 1'b1;
                  for (int i = 0; i < CODE_LENGTH; i++) begin
                     digit_in[i] = '0;
                  end
               end
            end else if (in_key_ff inside {[KEY_DIGIT_LO:KEY_ZERO]}) begin
               if (cnt_ff < CNT_W'(CODE_LENGTH)) begin
                  for (int i = 0; i < CODE_LENGTH; i++) begin
                     if (cnt_ff == CNT_W'(i)) begin
                        digit_in[i] = (in_key_ff == KEY_ZERO) ? '0 : in_key_ff[DIGIT_W-1:0];
                     end
                  end
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  err_in = 1'b1;
               end
            end
         end else if (in_key_ff == KEY_CLEAR) begin
            // counting or alarm: back to code entry
            mode_in = MODE_ENTRY;
            cnt_in  = '0;
            secs_in = '0;
            ms_in   = '0;
            beep_in = '0;
            tone_in = 1'b0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
               digit_in[i] = '0;
            end
         end
      end else if (mode_ff == MODE_COUNT) begin
         if (beep_inc >= half_ff) begin
            beep_in = '0;
            tone_in = !tone_ff;
         end else begin
            beep_in = beep_inc;
         end
         if (ms_inc >= MS_W'(TICKS_PER_SECOND)) begin
            ms_in = '0;
            // zero seconds loaded: stays counting with seconds held
            if (secs_ff != '0) begin
               secs_in = secs_dec;
               half_in = half_dec;
               if (secs_dec == '0) begin
                  mode_in = MODE_ALARM;
                  tone_in = 1'b1;
               end
            end
         end else begin
            ms_in = ms_inc;
         end
      end
   end

   always_comb begin
      packed_in = '0;
      for (int i = 0; i < PACK_N; i++) begin
         packed_in[4*i +: 4] = digit_in[i];
      end
   end

   // digit_count shows the low three bits of the counter
   assign cnt_ext = {3'b0, cnt_in};

   // lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENTRY;
         cnt_ff  <= '0;
         secs_ff <= '0;
         ms_ff   <= '0;
         half_ff <= '0;
         beep_ff <= '0;
         tone_ff <= 1'b0;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            digit_ff[i] <= '0;
         end
      end else if (step_en) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         secs_ff <= secs_in;
         ms_ff   <= ms_in;
         half_ff <= half_in;
         beep_ff <= beep_in;
         tone_ff <= tone_in;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_mode_ff   <= mode_in;
         out_cnt_ff    <= cnt_ext[DCNT_W-1:0];
         out_digits_ff <= packed_in;
         out_secs_ff   <= secs_in;
         out_tone_ff   <= tone_in;
         out_err_ff    <= err_in;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.mode           = out_mode_ff;
   assign rsp_chan.digit_count    = out_cnt_ff;
   assign rsp_chan.entered_digits = out_digits_ff;
   assign rsp_chan.seconds_left   = out_secs_ff;
   assign rsp_chan.tone_enable    = out_tone_ff;
   assign rsp_chan.error_flag     = out_err_ff;

   // errors only come from code entry
   a_err_in_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error_flag |-> rsp_chan.mode == MODE_ENTRY)
      else $error("error flag outside code entry");

   // alarm always sounds
   a_alarm_tone: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ALARM |-> tone_ff)
      else $error("alarm without tone");

   // code entry keeps the countdown idle
   a_entry_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ENTRY |-> secs_ff == '0 && !tone_ff)
      else $error("countdown state active in code entry");

   // digit counter never passes the code length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CODE_LENGTH))
      else $error("digit counter overflow");

   // a held input transaction lands in the state exactly when the response frees
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_vld_ff)
      else $error("transaction lost between stages");

endmodule
